>>> src/key_debounce_hold_timer_macros.svh
// assertion macros for the key debounce hold timer
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef KEY_DEBOUNCE_HOLD_TIMER_MACROS_SVH
`define KEY_DEBOUNCE_HOLD_TIMER_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif

`endif

>>> src/kdht_pkg.sv
// shared types and constants for the key debounce hold timer
// no dependencies
package kdht_pkg;

    localparam int PIN_KEYS = 4;
    localparam int KEY_W    = 2;
    localparam int TS_W     = 32;
    localparam int CNT_W    = 16;
    localparam int PIN_W    = 4;
    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 16'd20;

    typedef enum logic {
        OP_EDGE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key_id;
        logic             press_edge;
        logic [TS_W-1:0]  timestamp;
        logic [PIN_W-1:0] pin_levels;
    } item_t;

    typedef struct packed {
        logic [PIN_KEYS-1:0]           mask;
        logic [PIN_KEYS-1:0][TS_W-1:0] dur;
    } release_t;

endpackage

>>> src/kdht_in_stage.sv
// input register for edge and tick requests
// depends on kdht_pkg
module kdht_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  kdht_pkg::item_t s_item,
    input  logic            bank_free,
    output logic            fire,
    output logic            in_valid,
    output kdht_pkg::item_t item
);
    import kdht_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    logic  take;
    logic  accept;

    always_comb begin
        take      = valid_reg && ((item_reg.op == OP_EDGE) || bank_free);
        s_ready   = !valid_reg || take;
        accept    = s_valid && s_ready;
        valid_next = accept ? 1'b1 : (take ? 1'b0 : valid_reg);
        item_next  = accept ? s_item : item_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign fire     = take;
    assign in_valid = valid_reg;
    assign item     = item_reg;

endmodule

>>> src/kdht_keys.sv
// per-key debounce state machines, press and release timestamps, debounce register
// depends on kdht_pkg
module kdht_keys #(
    parameter int ACT_KEYS = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    input  logic [kdht_pkg::CNT_W-1:0] cfg_data,
    input  logic                       fire,
    input  kdht_pkg::item_t            item,
    output kdht_pkg::release_t         rel
);
    import kdht_pkg::*;

    typedef enum logic [1:0] {
        PH_UP,
        PH_UP_TO_DOWN,
        PH_DOWN,
        PH_DOWN_TO_UP
    } phase_t;

    phase_t           phase_reg   [ACT_KEYS];
    phase_t           phase_next  [ACT_KEYS];
    logic [CNT_W-1:0] count_reg   [ACT_KEYS];
    logic [CNT_W-1:0] count_next  [ACT_KEYS];
    logic [TS_W-1:0]  press_reg   [ACT_KEYS];
    logic [TS_W-1:0]  press_next  [ACT_KEYS];
    logic [TS_W-1:0]  release_reg [ACT_KEYS];
    logic [TS_W-1:0]  release_next[ACT_KEYS];
    logic [CNT_W-1:0] debounce_reg, debounce_next;
    logic [CNT_W-1:0] load_val;

    always_comb begin
        load_val      = (debounce_reg == '0) ? CNT_W'(1) : debounce_reg;
        debounce_next = cfg_valid ? cfg_data : debounce_reg;
        rel           = '0;
        for (int k = 0; k < ACT_KEYS; k++) begin
            phase_next[k]   = phase_reg[k];
            count_next[k]   = count_reg[k];
            press_next[k]   = press_reg[k];
            release_next[k] = release_reg[k];
            rel.dur[k]      = release_reg[k] - press_reg[k];
            if (fire) begin
                if (item.op == OP_EDGE) begin
                    if (item.key_id == KEY_W'(k)) begin
                        if (phase_reg[k] == PH_UP && item.press_edge) begin
                            press_next[k] = item.timestamp;
                            count_next[k] = load_val;
                            phase_next[k] = PH_UP_TO_DOWN;
                        end else if (phase_reg[k] == PH_DOWN && !item.press_edge) begin
                            release_next[k] = item.timestamp;
                            count_next[k]   = load_val;
                            phase_next[k]   = PH_DOWN_TO_UP;
                        end
                    end
                end else if (count_reg[k] != '0) begin
                    count_next[k] = count_reg[k] - CNT_W'(1);
                    // countdown expires: pin level settles the phase
                    if (count_reg[k] == CNT_W'(1)) begin
                        case (phase_reg[k])
                            PH_UP_TO_DOWN: begin
                                phase_next[k] = item.pin_levels[k] ? PH_UP : PH_DOWN;
                            end
                            PH_DOWN_TO_UP: begin
                                if (item.pin_levels[k]) begin
                                    phase_next[k] = PH_UP;
                                    rel.mask[k]   = 1'b1;
                                end else begin
                                    phase_next[k] = PH_DOWN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
            for (int k = 0; k < ACT_KEYS; k++) begin
                phase_reg[k]   <= PH_UP;
                count_reg[k]   <= '0;
                press_reg[k]   <= '0;
                release_reg[k] <= '0;
            end
        end else begin
            debounce_reg <= debounce_next;
            for (int k = 0; k < ACT_KEYS; k++) begin
                phase_reg[k]   <= phase_next[k];
                count_reg[k]   <= count_next[k];
                press_reg[k]   <= press_next[k];
                release_reg[k] <= release_next[k];
            end
        end
    end

endmodule

>>> src/kdht_results.sv
// result bank: confirmed releases of one tick, sent out in rising key order
// depends on kdht_pkg
module kdht_results (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load_en,
    input  kdht_pkg::release_t         rel,
    output logic                       bank_free,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [kdht_pkg::KEY_W-1:0] m_released_key,
    output logic [kdht_pkg::TS_W-1:0]  m_hold_duration,
    output logic                       m_last_result
);
    import kdht_pkg::*;

    logic [PIN_KEYS-1:0]           mask_reg, mask_next;
    logic [PIN_KEYS-1:0][TS_W-1:0] dur_reg, dur_next;
    logic [KEY_W-1:0]              sel;
    logic                          single;

    always_comb begin
        sel = '0;
        for (int k = PIN_KEYS - 1; k >= 0; k--) begin
            if (mask_reg[k]) begin
                sel = KEY_W'(k);
            end
        end
        single    = (mask_reg & (mask_reg - PIN_KEYS'(1))) == '0;
        m_valid   = mask_reg != '0;
        bank_free = !m_valid || (single && m_ready);
        if (load_en) begin
            mask_next = rel.mask;
            dur_next  = rel.dur;
        end else begin
            mask_next = (m_valid && m_ready) ? (mask_reg & (mask_reg - PIN_KEYS'(1)))
                                             : mask_reg;
            dur_next  = dur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
        dur_reg <= dur_next;
    end

    assign m_released_key  = sel;
    assign m_hold_duration = dur_reg[sel];
    assign m_last_result   = single;

endmodule

>>> src/key_debounce_hold_timer.sv
// key debounce hold timer: per-key debounce machines with hold duration report
// depends on kdht_pkg, kdht_in_stage, kdht_keys, kdht_results and the macros header
//
// usage:
//   s_ channel carries edge requests (op 0: key_id, press_edge, timestamp) and
//   tick requests (op 1: pin_levels, active low). cfg_valid writes debounce_ticks
//   from cfg_data; cfg_ready is always high, write only while the block is idle.
//   m_ channel carries one request per confirmed release: released_key,
//   hold_duration and last_result, which marks the final release of a tick.
//   an accepted request waits in the input register until taken; key state and
//   result bank then update together, so m_ shows releases with the new state.
//   throughput: one request per cycle unless a tick waits on the result bank; a
//   tick that confirms n releases loads n results, and a following tick waits in
//   the input register until the bank's last result is taken. edges pass while
//   the bank drains. a stalled receiver holds the current result and, once the
//   input register is occupied by a tick, s_ready.
//   reset: all keys up, countdowns stopped, timestamps zero, debounce_ticks 20,
//   result bank and input register empty.
//   keys at or above NUM_KEYS have no state and never report a release.
module key_debounce_hold_timer #(
    parameter int NUM_KEYS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [1:0]  s_key_id,
    input  logic        s_press_edge,
    input  logic [31:0] s_timestamp,
    input  logic [3:0]  s_pin_levels,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_released_key,
    output logic [31:0] m_hold_duration,
    output logic        m_last_result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import kdht_pkg::*;

    `include "key_debounce_hold_timer_macros.svh"

    localparam int ACT_KEYS = (NUM_KEYS < PIN_KEYS) ? NUM_KEYS : PIN_KEYS;

    item_t    s_item;
    item_t    item;
    release_t rel;
    logic     bank_free;
    logic     fire;
    logic     in_valid;

    assign s_item.op         = op_t'(s_op);
    assign s_item.key_id     = s_key_id;
    assign s_item.press_edge = s_press_edge;
    assign s_item.timestamp  = s_timestamp;
    assign s_item.pin_levels = s_pin_levels;
    assign cfg_ready         = 1'b1;

    kdht_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .bank_free (bank_free),
        .fire      (fire),
        .in_valid  (in_valid),
        .item      (item)
    );

    kdht_keys #(
        .ACT_KEYS (ACT_KEYS)
    ) u_keys (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item),
        .rel       (rel)
    );

    kdht_results u_results (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load_en         (fire && (item.op == OP_TICK)),
        .rel             (rel),
        .bank_free       (bank_free),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_released_key  (m_released_key),
        .m_hold_duration (m_hold_duration),
        .m_last_result   (m_last_result)
    );

    // accepted request lands in the input register
    `ASSERT_NEXT(a_accept_held, aclk, aresetn, s_valid && s_ready, in_valid)
    // a waiting request keeps its contents
    `ASSERT_NEXT(a_wait_stable, aclk, aresetn, in_valid && !fire, in_valid && $stable(item))
    // more releases of the same tick follow without a gap
    `ASSERT_NEXT(a_tick_burst, aclk, aresetn, m_valid && m_ready && !m_last_result, m_valid)
    // a tick never overwrites results still waiting
    `ASSERT_IMPLIES(a_no_overwrite, aclk, aresetn, fire && (item.op == OP_TICK),
                    !m_valid || (m_ready && m_last_result))

endmodule

>>> sim/key_debounce_hold_timer_tb.sv
`timescale 1ns / 100ps

// testbench for key_debounce_hold_timer: edge and tick requests with random gaps and
// stalls, confirmed releases predicted per key and checked in order; uses kdht_pkg
module key_debounce_hold_timer_tb;
    import kdht_pkg::*;

    localparam int NUM_KEYS     = PIN_KEYS;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {
        KEY_UP      = 2'd0,
        KEY_FALLING = 2'd1,
        KEY_DOWN    = 2'd2,
        KEY_RISING  = 2'd3
    } key_phase_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TS_W-1:0]  held;
        logic             last;
    } hold_report_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_op;
    logic [KEY_W-1:0]  s_key_id;
    logic              s_press_edge;
    logic [TS_W-1:0]   s_timestamp;
    logic [PIN_W-1:0]  s_pin_levels;
    logic              m_valid;
    logic              m_ready;
    logic [KEY_W-1:0]  m_released_key;
    logic [TS_W-1:0]   m_hold_duration;
    logic              m_last_result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data;

    key_phase_t        key_phase [NUM_KEYS];
    logic [CNT_W-1:0]  countdown [NUM_KEYS];
    logic [TS_W-1:0]   press_ts [NUM_KEYS];
    logic [TS_W-1:0]   release_ts [NUM_KEYS];
    logic [CNT_W-1:0]  debounce_ticks;
    logic [TS_W-1:0]   clock_ts;
    hold_report_t      expected_releases [$];
    int                mismatch_count = 0;
    int                max_gap = 7;
    int                max_stall = 7;

    key_debounce_hold_timer #(
        .NUM_KEYS(NUM_KEYS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_key_id(s_key_id),
        .s_press_edge(s_press_edge),
        .s_timestamp(s_timestamp),
        .s_pin_levels(s_pin_levels),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_released_key(m_released_key),
        .m_hold_duration(m_hold_duration),
        .m_last_result(m_last_result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // updates the key model and queues the releases a tick confirms
    function automatic void predict_releases(input op_t op, input logic [KEY_W-1:0] key,
            input logic press, input logic [TS_W-1:0] ts, input logic [PIN_W-1:0] pins);
        hold_report_t     batch [$];
        hold_report_t     rec;
        logic [CNT_W-1:0] load;
        load = (debounce_ticks == '0) ? CNT_W'(1) : debounce_ticks;
        if (op == OP_EDGE) begin
            if (key_phase[key] == KEY_UP && press) begin
                press_ts[key] = ts;
                countdown[key] = load;
                key_phase[key] = KEY_FALLING;
            end else if (key_phase[key] == KEY_DOWN && !press) begin
                release_ts[key] = ts;
                countdown[key] = load;
                key_phase[key] = KEY_RISING;
            end
        end else begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (countdown[k] != '0) begin
                    countdown[k] = countdown[k] - 1'b1;
                    if (countdown[k] == '0) begin
                        if (key_phase[k] == KEY_FALLING) begin
                            key_phase[k] = pins[k] ? KEY_UP : KEY_DOWN;
                        end else if (key_phase[k] == KEY_RISING) begin
                            if (!pins[k]) begin
                                key_phase[k] = KEY_DOWN;
                            end else begin
                                key_phase[k] = KEY_UP;
                                rec.key = KEY_W'(k);
                                rec.held = release_ts[k] - press_ts[k];
                                rec.last = 1'b0;
                                batch.push_back(rec);
                            end
                        end
                    end
                end
            end
            if (batch.size() > 0) begin
                rec = batch.pop_back();
                rec.last = 1'b1;
                batch.push_back(rec);
            end
            foreach (batch[i]) expected_releases.push_back(batch[i]);
        end
    endfunction

    task automatic send_request(input op_t op, input logic [KEY_W-1:0] key, input logic press,
            input logic [TS_W-1:0] ts, input logic [PIN_W-1:0] pins);
        int gap;
        gap = $urandom_range(max_gap, 0);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_op = op;
        s_key_id = key;
        s_press_edge = press;
        s_timestamp = ts;
        s_pin_levels = pins;
        s_valid = 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_releases(op, key, press, ts, pins);
        @(negedge aclk);
    endtask

    task automatic send_edge(input logic [KEY_W-1:0] key, input logic press,
            input logic [TS_W-1:0] ts);
        send_request(OP_EDGE, key, press, ts, PIN_W'($urandom));
    endtask

    task automatic send_tick(input logic [PIN_W-1:0] pins);
        send_request(OP_TICK, KEY_W'($urandom), 1'($urandom_range(1, 0)), TS_W'($urandom),
                     pins);
    endtask

    // wait for outstanding releases, then let the pipeline empty
    task automatic settle(input int bound);
        int waited;
        s_valid = 1'b0;
        waited = 0;
        while (expected_releases.size() != 0 && waited < bound) begin
            @(negedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_debounce(input logic [CNT_W-1:0] value);
        settle(100000);
        cfg_data = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        debounce_ticks = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_random(input int items);
        int               roll;
        int               pick;
        logic [KEY_W-1:0] key;
        logic [PIN_W-1:0] pins;
        logic             press;
        logic [TS_W-1:0]  ts;
        for (int n = 0; n < items; n++) begin
            roll = $urandom_range(99, 0);
            clock_ts = clock_ts + $urandom_range(400, 0);
            if (roll < 55) begin
                // pins mostly agree with the direction each settling key is heading
                for (int k = 0; k < NUM_KEYS; k++) begin
                    case (key_phase[k])
                        KEY_FALLING: pins[k] = ($urandom_range(99, 0) < 20);
                        KEY_RISING:  pins[k] = ($urandom_range(99, 0) >= 20);
                        default:     pins[k] = 1'($urandom_range(1, 0));
                    endcase
                end
                send_tick(pins);
            end else begin
                key = KEY_W'($urandom_range(NUM_KEYS - 1, 0));
                if (roll < 92 && key_phase[key] == KEY_UP) begin
                    press = 1'b1;
                end else if (roll < 92 && key_phase[key] == KEY_DOWN) begin
                    press = 1'b0;
                end else begin
                    press = 1'($urandom_range(1, 0));
                end
                pick = $urandom_range(99, 0);
                if (pick < 4) begin
                    ts = '0;
                end else if (pick < 8) begin
                    ts = '1;
                end else if (pick < 20) begin
                    ts = $urandom;
                end else begin
                    ts = clock_ts;
                end
                send_edge(key, press, ts);
            end
        end
    endtask

    task automatic test_directed;
        // reset debounce: one press settles on exactly the twentieth tick
        send_edge(2'd2, 1'b1, 32'h0000_0000);
        repeat (19) send_tick(4'b1111);
        send_tick(4'b1011);
        write_debounce(16'd1);
        send_edge(2'd1, 1'b0, 32'h1234_5678);
        send_edge(2'd0, 1'b1, 32'hFFFF_FFFF);
        send_edge(2'd1, 1'b1, 32'h0000_0001);
        send_edge(2'd3, 1'b1, 32'h8000_0000);
        send_edge(2'd0, 1'b1, 32'h0000_0000);
        send_tick(4'b0000);
        send_edge(2'd2, 1'b1, 32'h0000_0010);
        send_edge(2'd0, 1'b0, 32'h0000_0000);
        send_edge(2'd1, 1'b0, 32'h0000_0000);
        send_edge(2'd2, 1'b0, 32'hFFFF_FFFF);
        send_edge(2'd3, 1'b0, 32'h8000_0005);
        send_edge(2'd3, 1'b0, 32'h0000_0000);
        // all four keys confirm on one tick
        send_tick(4'b1111);
        send_edge(2'd0, 1'b1, 32'd100);
        send_edge(2'd1, 1'b1, 32'd200);
        send_tick(4'b1110);
        send_edge(2'd0, 1'b0, 32'd150);
        // release bounces back to down
        send_tick(4'b1110);
        send_tick(4'b0101);
        send_edge(2'd0, 1'b0, 32'd350);
        send_tick(4'b1111);
    endtask

    task automatic test_zero_debounce;
        write_debounce(16'd0);
        send_edge(2'd3, 1'b1, TS_W'($urandom));
        send_tick(4'b0111);
        send_edge(2'd3, 1'b0, TS_W'($urandom));
        send_tick(4'b1000);
    endtask

    task automatic test_long_debounce;
        max_gap = 0;
        max_stall = 0;
        write_debounce(16'd32);
        send_edge(2'd1, 1'b1, TS_W'($urandom));
        repeat (31) send_tick(PIN_W'($urandom));
        send_tick(PIN_W'($urandom) & 4'b1101);
        send_edge(2'd1, 1'b0, TS_W'($urandom));
        repeat (31) send_tick(PIN_W'($urandom));
        send_tick(PIN_W'($urandom) | 4'b0010);
    endtask

    task automatic test_random_default;
        max_gap = 7;
        max_stall = 7;
        write_debounce(DEBOUNCE_RESET);
        run_random(90);
    endtask

    task automatic test_random_no_idle;
        max_gap = 0;
        max_stall = 0;
        write_debounce(16'd1);
        run_random(76);
    endtask

    task automatic test_random_backpressure;
        max_gap = 0;
        max_stall = 7;
        write_debounce(16'd3);
        run_random(76);
    endtask

    task automatic test_random_mixed;
        max_gap = 3;
        max_stall = 7;
        write_debounce(16'd2);
        run_random(76);
    endtask

    // result side stall per request
    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            stall = $urandom_range(max_stall, 0);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    always @(posedge aclk) begin
        hold_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_releases.size() == 0) begin
                $display("%0t: unexpected release, expected none, actual key %0d hold %h last %b",
                         $time, m_released_key, m_hold_duration, m_last_result);
                mismatch_count++;
            end else begin
                want = expected_releases.pop_front();
                if (m_released_key !== want.key) begin
                    $display("%0t: released_key expected %0d actual %0d",
                             $time, want.key, m_released_key);
                    mismatch_count++;
                end
                if (m_hold_duration !== want.held) begin
                    $display("%0t: hold_duration expected %h actual %h",
                             $time, want.held, m_hold_duration);
                    mismatch_count++;
                end
                if (m_last_result !== want.last) begin
                    $display("%0t: last_result expected %b actual %b",
                             $time, want.last, m_last_result);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        s_valid = 1'b0;
        s_op = OP_EDGE;
        s_key_id = '0;
        s_press_edge = 1'b0;
        s_timestamp = '0;
        s_pin_levels = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        aresetn = 1'b0;
        debounce_ticks = DEBOUNCE_RESET;
        clock_ts = $urandom;
        for (int k = 0; k < NUM_KEYS; k++) begin
            key_phase[k] = KEY_UP;
            countdown[k] = '0;
            press_ts[k] = '0;
            release_ts[k] = '0;
        end
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed;
        test_zero_debounce;
        test_long_debounce;
        test_random_default;
        test_random_no_idle;
        test_random_backpressure;
        test_random_mixed;
        settle(20000);
        if (expected_releases.size() != 0) begin
            $display("%0t: releases outstanding, expected 0 actual %0d",
                     $time, expected_releases.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("key_debounce_hold_timer verification clean");
        end else begin
            $display("key_debounce_hold_timer verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("key_debounce_hold_timer verification failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/kdht_pkg.sv
src/kdht_in_stage.sv
src/kdht_keys.sv
src/kdht_results.sv
src/key_debounce_hold_timer.sv
sim/key_debounce_hold_timer_tb.sv
